// ===== design/nbgs_pkg.sv =====
// nbgs_pkg: shared constants, command/status types and arithmetic helpers
// for the n-body gravity step unit. Used by all nbgs_* modules except the RAM.
`default_nettype none
package nbgs_pkg;

    // Capacity and fixed-point format
    localparam int MAX_BODIES = 64;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int WORD_W     = 32;
    localparam int MASS_W     = 16;
    localparam int CFG_IDX_W  = 2;

    // Pair arithmetic widths
    localparam int SQ_W   = 2 * WORD_W - FRAC_BITS;      // dx^2 >> F
    localparam int S_W    = SQ_W + 2;                    // dx^2 + dy^2 + eps
    localparam int SQX_W  = 2 * ((S_W + FRAC_BITS + 1) / 2);
    localparam int ROOT_W = SQX_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int DEN_W  = S_W + ROOT_W;
    localparam int KM_W   = WORD_W + MASS_W;
    localparam int PROD_W = KM_W + WORD_W;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int QUO_W  = WORD_W - 1;                  // saturating quotient
    localparam int DREM_W = DEN_W + 1;
    localparam int SATC_W = DEN_W + QUO_W;
    localparam int ACC_W  = WORD_W + IDX_W + 1;
    localparam int ITER_W = $clog2(ROOT_W);
    localparam int DTP_W  = 2 * WORD_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRAV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT  = 2'd2;

    localparam logic [WORD_W-1:0] GRAV_RST = 32'd437406925;
    localparam logic [WORD_W-1:0] DT_RST   = 32'd429497;
    localparam logic [WORD_W-1:0] SOFT_RST = 32'd65536;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_LATI = 4'd1;
    localparam logic [OP_W-1:0] OP_DIFF = 4'd2;
    localparam logic [OP_W-1:0] OP_SQ   = 4'd3;
    localparam logic [OP_W-1:0] OP_SUM  = 4'd4;
    localparam logic [OP_W-1:0] OP_ROOT = 4'd5;
    localparam logic [OP_W-1:0] OP_DEN0 = 4'd6;
    localparam logic [OP_W-1:0] OP_DEN1 = 4'd7;
    localparam logic [OP_W-1:0] OP_NUM0 = 4'd8;
    localparam logic [OP_W-1:0] OP_NUM1 = 4'd9;
    localparam logic [OP_W-1:0] OP_DIVI = 4'd10;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd11;
    localparam logic [OP_W-1:0] OP_ACC  = 4'd12;
    localparam logic [OP_W-1:0] OP_WRA  = 4'd13;
    localparam logic [OP_W-1:0] OP_INT1 = 4'd14;
    localparam logic [OP_W-1:0] OP_INT4 = 4'd15;

    // Controller to datapath
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] wr_addr;
        logic             load_we;
        logic             int_vel;   // velocity update stage
        logic             int_mul;   // second dt product stage
        logic             ovf;
        logic             final_item;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic s_zero;
        logic root_last;
        logic div_last;
        logic out_fire;
    } status_t;

    localparam logic signed [ACC_W-1:0] SAT_POS =
        {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_NEG =
        {{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
    localparam logic signed [DTP_W-1:0] DT_HALF =
        {{(DTP_W-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}};

    // Saturate to signed word
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] x);
        logic signed [WORD_W-1:0] r;
        if (x > SAT_POS) begin
            r = SAT_POS[WORD_W-1:0];
        end else if (x < SAT_NEG) begin
            r = SAT_NEG[WORD_W-1:0];
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

    // (p + 2^31) >> 32, floor shift: round half up of a dt product
    function automatic logic signed [WORD_W:0] dt_round(input logic signed [DTP_W-1:0] p);
        logic signed [DTP_W-1:0] t;
        t = p + DT_HALF;
        return t[DTP_W-1:WORD_W];
    endfunction

endpackage
`default_nettype wire

// ===== design/nbgs_ram.sv =====
// nbgs_ram: generic simple dual-port RAM, one write port, one registered read.
// No dependencies.
`default_nettype none
module nbgs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/nbgs_ctrl.sv =====
// nbgs_ctrl: sequencer for load, all-pairs acceleration and integration.
// Depends on nbgs_pkg; drives nbgs_dpath through cmd_t, reads status_t.
`default_nettype none
module nbgs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_last,
    output logic                  s_ready,
    input  wire nbgs_pkg::status_t stat,
    output nbgs_pkg::cmd_t        cmd
);
    import nbgs_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_LOAD = 5'd0;
    localparam logic [ST_W-1:0] ST_RDI  = 5'd1;
    localparam logic [ST_W-1:0] ST_LATI = 5'd2;
    localparam logic [ST_W-1:0] ST_RDJ  = 5'd3;
    localparam logic [ST_W-1:0] ST_DIFF = 5'd4;
    localparam logic [ST_W-1:0] ST_SQ   = 5'd5;
    localparam logic [ST_W-1:0] ST_SUM  = 5'd6;
    localparam logic [ST_W-1:0] ST_CHK  = 5'd7;
    localparam logic [ST_W-1:0] ST_ROOT = 5'd8;
    localparam logic [ST_W-1:0] ST_DEN0 = 5'd9;
    localparam logic [ST_W-1:0] ST_DEN1 = 5'd10;
    localparam logic [ST_W-1:0] ST_NUM0 = 5'd11;
    localparam logic [ST_W-1:0] ST_NUM1 = 5'd12;
    localparam logic [ST_W-1:0] ST_DIVI = 5'd13;
    localparam logic [ST_W-1:0] ST_DIV  = 5'd14;
    localparam logic [ST_W-1:0] ST_ACC  = 5'd15;
    localparam logic [ST_W-1:0] ST_NXTJ = 5'd16;
    localparam logic [ST_W-1:0] ST_WRA  = 5'd17;
    localparam logic [ST_W-1:0] ST_IRD  = 5'd18;
    localparam logic [ST_W-1:0] ST_I1   = 5'd19;
    localparam logic [ST_W-1:0] ST_I2   = 5'd20;
    localparam logic [ST_W-1:0] ST_I3   = 5'd21;
    localparam logic [ST_W-1:0] ST_I4   = 5'd22;
    localparam logic [ST_W-1:0] ST_IOUT = 5'd23;

    logic [ST_W-1:0]  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic             i_last, j_last, k_last;

    assign i_last = (CNT_W'(i_reg) + CNT_W'(1)) == count_reg;
    assign j_last = (CNT_W'(j_reg) + CNT_W'(1)) == count_reg;
    assign k_last = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        s_ready    = 1'b0;
        cmd            = '0;
        cmd.op         = OP_NONE;
        cmd.rd_addr    = j_reg;
        cmd.wr_addr    = count_reg[IDX_W-1:0];
        cmd.ovf        = ovf_reg;
        cmd.final_item = k_last;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (count_reg < CNT_W'(MAX_BODIES)) begin
                        cmd.load_we = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        i_next     = '0;
                        state_next = ST_RDI;
                    end
                end
            end
            ST_RDI: begin
                cmd.rd_addr = i_reg;
                j_next      = '0;
                state_next  = ST_LATI;
            end
            ST_LATI: begin
                cmd.op     = OP_LATI;
                state_next = ST_RDJ;
            end
            ST_RDJ: begin
                state_next = (j_reg == i_reg) ? ST_NXTJ : ST_DIFF;
            end
            ST_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.op     = OP_SQ;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.op     = OP_SUM;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                // coincident bodies without softening add nothing
                state_next = stat.s_zero ? ST_NXTJ : ST_ROOT;
            end
            ST_ROOT: begin
                cmd.op = OP_ROOT;
                if (stat.root_last) begin
                    state_next = ST_DEN0;
                end
            end
            ST_DEN0: begin
                cmd.op     = OP_DEN0;
                state_next = ST_DEN1;
            end
            ST_DEN1: begin
                cmd.op     = OP_DEN1;
                state_next = ST_NUM0;
            end
            ST_NUM0: begin
                cmd.op     = OP_NUM0;
                state_next = ST_NUM1;
            end
            ST_NUM1: begin
                cmd.op     = OP_NUM1;
                state_next = ST_DIVI;
            end
            ST_DIVI: begin
                cmd.op     = OP_DIVI;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (stat.div_last) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.op     = OP_ACC;
                state_next = ST_NXTJ;
            end
            ST_NXTJ: begin
                if (j_last) begin
                    state_next = ST_WRA;
                end else begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = ST_RDJ;
                end
            end
            ST_WRA: begin
                cmd.op      = OP_WRA;
                cmd.wr_addr = i_reg;
                if (i_last) begin
                    k_next     = '0;
                    state_next = ST_IRD;
                end else begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_RDI;
                end
            end
            ST_IRD: begin
                cmd.rd_addr = k_reg;
                state_next  = ST_I1;
            end
            ST_I1: begin
                cmd.op     = OP_INT1;
                state_next = ST_I2;
            end
            ST_I2: begin
                cmd.int_vel = 1'b1;
                state_next  = ST_I3;
            end
            ST_I3: begin
                cmd.int_mul = 1'b1;
                state_next  = ST_I4;
            end
            ST_I4: begin
                cmd.op      = OP_INT4;
                cmd.rd_addr = k_reg;
                state_next  = ST_IOUT;
            end
            ST_IOUT: begin
                if (stat.out_fire) begin
                    if (k_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_IRD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/nbgs_dpath.sv =====
// nbgs_dpath: body stores, pair force arithmetic (root, products, divider),
// integration and output register. Depends on nbgs_pkg and nbgs_ram.
`default_nettype none
module nbgs_dpath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire nbgs_pkg::cmd_t                    cmd,
    output nbgs_pkg::status_t                      stat,
    input  wire logic                              cfg_wr_en,
    input  wire logic [nbgs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nbgs_pkg::WORD_W-1:0]       cfg_wr_data,
    input  wire logic signed [nbgs_pkg::WORD_W-1:0] s_pos_x,
    input  wire logic signed [nbgs_pkg::WORD_W-1:0] s_pos_y,
    input  wire logic signed [nbgs_pkg::WORD_W-1:0] s_vel_x,
    input  wire logic signed [nbgs_pkg::WORD_W-1:0] s_vel_y,
    input  wire logic [nbgs_pkg::MASS_W-1:0]       s_mass,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [nbgs_pkg::IDX_W-1:0]             m_body_index,
    output logic signed [nbgs_pkg::WORD_W-1:0]     m_new_pos_x,
    output logic signed [nbgs_pkg::WORD_W-1:0]     m_new_pos_y,
    output logic signed [nbgs_pkg::WORD_W-1:0]     m_new_vel_x,
    output logic signed [nbgs_pkg::WORD_W-1:0]     m_new_vel_y,
    output logic                                   m_overflowed,
    output logic                                   m_final_res
);
    import nbgs_pkg::*;

    // Configuration registers
    logic [WORD_W-1:0] grav_reg, dt_reg, soft_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= GRAV_RST;
            dt_reg   <= DT_RST;
            soft_reg <= SOFT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GRAV: grav_reg <= cfg_wr_data;
                REG_DT:   grav_reg <= grav_reg;
                default:  grav_reg <= grav_reg;
            endcase
            if (cfg_index == REG_DT) begin
                dt_reg <= cfg_wr_data;
            end
            if (cfg_index == REG_SOFT) begin
                soft_reg <= cfg_wr_data;
            end
        end
    end

    // Body stores
    logic [2*WORD_W-1:0] pos_rdata, vel_rdata, acc_rdata, acc_wdata;
    logic [MASS_W-1:0]   mass_rdata;

    nbgs_ram #(.WIDTH(2*WORD_W), .DEPTH(MAX_BODIES)) u_pos_ram (
        .aclk(aclk), .we(cmd.load_we), .waddr(cmd.wr_addr),
        .wdata({s_pos_y, s_pos_x}), .raddr(cmd.rd_addr), .rdata(pos_rdata)
    );
    nbgs_ram #(.WIDTH(2*WORD_W), .DEPTH(MAX_BODIES)) u_vel_ram (
        .aclk(aclk), .we(cmd.load_we), .waddr(cmd.wr_addr),
        .wdata({s_vel_y, s_vel_x}), .raddr(cmd.rd_addr), .rdata(vel_rdata)
    );
    nbgs_ram #(.WIDTH(MASS_W), .DEPTH(MAX_BODIES)) u_mass_ram (
        .aclk(aclk), .we(cmd.load_we), .waddr(cmd.wr_addr),
        .wdata(s_mass), .raddr(cmd.rd_addr), .rdata(mass_rdata)
    );
    nbgs_ram #(.WIDTH(2*WORD_W), .DEPTH(MAX_BODIES)) u_acc_ram (
        .aclk(aclk), .we(cmd.op == OP_WRA), .waddr(cmd.wr_addr),
        .wdata(acc_wdata), .raddr(cmd.rd_addr), .rdata(acc_rdata)
    );

    // Pair and integration registers, lane 0 is x and lane 1 is y
    logic [WORD_W-1:0]        pi_reg   [2];
    logic                     dneg_reg [2];
    logic [WORD_W-1:0]        ud_reg   [2];
    logic [MASS_W-1:0]        mass_reg;
    logic [SQ_W-1:0]          sq_reg   [2];
    logic [KM_W-1:0]          km_reg;
    logic [S_W-1:0]           s_reg;
    logic [SQX_W-1:0]         sqx_reg;
    logic [REM_W-1:0]         srem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [ITER_W-1:0]        cnt_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [PROD_W-1:0]        num_reg  [2];
    logic [DREM_W-1:0]        drem_reg [2];
    logic [QUO_W-1:0]         nlow_reg [2];
    logic [QUO_W-1:0]         quo_reg  [2];
    logic                     sat_reg  [2];
    logic signed [ACC_W-1:0]  acc_reg  [2];
    logic signed [WORD_W-1:0] ipos_reg [2];
    logic signed [WORD_W-1:0] ivel_reg [2];
    logic signed [DTP_W-1:0]  prod_reg [2];
    logic signed [WORD_W-1:0] nvel_reg [2];
    logic                     mval_reg;

    // Combinational terms
    logic [WORD_W:0]          diff     [2];
    logic [WORD_W:0]          dmag     [2];
    logic [2*WORD_W-1:0]      sq_full  [2];
    logic [S_W-1:0]           s_next;
    logic [REM_W-1:0]         sq_trem, sq_trial;
    logic                     sq_ge;
    logic [WORD_W-1:0]        s_piece;
    logic [WORD_W+ROOT_W-1:0] den_prod;
    logic [WORD_W-1:0]        km_piece;
    logic [2*WORD_W-1:0]      num_prod [2];
    logic [NUM_W-1:0]         num_sh   [2];
    logic [DREM_W-1:0]        dv_t     [2];
    logic                     dv_ge    [2];
    logic [QUO_W-1:0]         mag      [2];
    logic signed [ACC_W-1:0]  term     [2];
    logic signed [WORD_W-1:0] lane_acc [2];
    logic [MASS_W-1:0]        mass_fix;

    always_comb begin
        // pair distance magnitude and square
        for (int l = 0; l < 2; l++) begin
            diff[l] = {pos_rdata[WORD_W*l+WORD_W-1], pos_rdata[WORD_W*l +: WORD_W]}
                    - {pi_reg[l][WORD_W-1], pi_reg[l]};
            dmag[l] = diff[l][WORD_W] ? (~diff[l] + (WORD_W+1)'(1)) : diff[l];
            sq_full[l] = {{WORD_W{1'b0}}, ud_reg[l]} * {{WORD_W{1'b0}}, ud_reg[l]};
            num_prod[l] = {{WORD_W{1'b0}}, km_piece} * {{WORD_W{1'b0}}, ud_reg[l]};
            num_sh[l] = NUM_W'(num_reg[l]) << FRAC_BITS;
            dv_t[l] = {drem_reg[l][DREM_W-2:0], nlow_reg[l][QUO_W-1]};
            dv_ge[l] = dv_t[l] >= {1'b0, den_reg};
            mag[l] = sat_reg[l] ? {QUO_W{1'b1}} : quo_reg[l];
            term[l] = dneg_reg[l] ? -$signed(ACC_W'(mag[l])) : $signed(ACC_W'(mag[l]));
            lane_acc[l] = $signed(acc_rdata[WORD_W*l +: WORD_W]);
        end
        s_next = S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(soft_reg);
        // one root bit per step
        sq_trem  = {srem_reg[REM_W-3:0], sqx_reg[SQX_W-1 -: 2]};
        sq_trial = REM_W'({root_reg, 2'b01});
        sq_ge    = sq_trem >= sq_trial;
        // split multiplies: low word first, high part next cycle
        s_piece  = (cmd.op == OP_DEN1) ? WORD_W'(s_reg >> WORD_W) : s_reg[WORD_W-1:0];
        den_prod = (WORD_W+ROOT_W)'(s_piece) * (WORD_W+ROOT_W)'(root_reg);
        km_piece = (cmd.op == OP_NUM1) ? WORD_W'(km_reg >> WORD_W) : km_reg[WORD_W-1:0];
        mass_fix = (mass_rdata == '0) ? MASS_W'(1) : mass_rdata;
        acc_wdata = {sat_word(acc_reg[1]), sat_word(acc_reg[0])};
    end

    // Pair arithmetic sequence
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATI: begin
                for (int l = 0; l < 2; l++) begin
                    pi_reg[l]  <= pos_rdata[WORD_W*l +: WORD_W];
                    acc_reg[l] <= '0;
                end
            end
            OP_DIFF: begin
                for (int l = 0; l < 2; l++) begin
                    dneg_reg[l] <= diff[l][WORD_W];
                    ud_reg[l]   <= dmag[l][WORD_W-1:0];
                end
                mass_reg <= mass_fix;
            end
            OP_SQ: begin
                for (int l = 0; l < 2; l++) begin
                    sq_reg[l] <= sq_full[l][2*WORD_W-1:FRAC_BITS];
                end
                km_reg <= KM_W'(grav_reg) * KM_W'(mass_reg);
            end
            OP_SUM: begin
                s_reg    <= s_next;
                sqx_reg  <= SQX_W'(s_next) << FRAC_BITS;
                srem_reg <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            OP_ROOT: begin
                srem_reg <= sq_ge ? (sq_trem - sq_trial) : sq_trem;
                root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                sqx_reg  <= sqx_reg << 2;
                cnt_reg  <= cnt_reg + ITER_W'(1);
            end
            OP_DEN0: begin
                den_reg <= DEN_W'(den_prod);
            end
            OP_DEN1: begin
                den_reg <= den_reg + (DEN_W'(den_prod) << WORD_W);
            end
            OP_NUM0: begin
                for (int l = 0; l < 2; l++) begin
                    num_reg[l] <= PROD_W'(num_prod[l]);
                end
            end
            OP_NUM1: begin
                for (int l = 0; l < 2; l++) begin
                    num_reg[l] <= num_reg[l] + (PROD_W'(num_prod[l]) << WORD_W);
                end
            end
            OP_DIVI: begin
                // quotient of 2^31 or more saturates
                for (int l = 0; l < 2; l++) begin
                    sat_reg[l]  <= SATC_W'(num_sh[l]) >= {den_reg, {QUO_W{1'b0}}};
                    drem_reg[l] <= DREM_W'(num_sh[l][NUM_W-1:QUO_W]);
                    nlow_reg[l] <= num_sh[l][QUO_W-1:0];
                    quo_reg[l]  <= '0;
                end
                cnt_reg <= '0;
            end
            OP_DIV: begin
                for (int l = 0; l < 2; l++) begin
                    drem_reg[l] <= dv_ge[l] ? (dv_t[l] - {1'b0, den_reg}) : dv_t[l];
                    quo_reg[l]  <= {quo_reg[l][QUO_W-2:0], dv_ge[l]};
                    nlow_reg[l] <= nlow_reg[l] << 1;
                end
                cnt_reg <= cnt_reg + ITER_W'(1);
            end
            OP_ACC: begin
                for (int l = 0; l < 2; l++) begin
                    acc_reg[l] <= acc_reg[l] + term[l];
                end
            end
            OP_INT1: begin
                for (int l = 0; l < 2; l++) begin
                    ipos_reg[l] <= $signed(pos_rdata[WORD_W*l +: WORD_W]);
                    ivel_reg[l] <= $signed(vel_rdata[WORD_W*l +: WORD_W]);
                    prod_reg[l] <= lane_acc[l] * $signed({1'b0, dt_reg});
                end
            end
            default: begin
                // velocity, then its dt product
                if (cmd.int_vel) begin
                    for (int l = 0; l < 2; l++) begin
                        nvel_reg[l] <= sat_word(ACC_W'(ivel_reg[l])
                                              + ACC_W'(dt_round(prod_reg[l])));
                    end
                end
                if (cmd.int_mul) begin
                    for (int l = 0; l < 2; l++) begin
                        prod_reg[l] <= nvel_reg[l] * $signed({1'b0, dt_reg});
                    end
                end
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mval_reg <= 1'b0;
        end else if (cmd.op == OP_INT4) begin
            mval_reg <= 1'b1;
        end else if (m_ready) begin
            mval_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_INT4) begin
            m_body_index <= cmd.rd_addr;
            m_new_pos_x  <= sat_word(ACC_W'(ipos_reg[0]) + ACC_W'(dt_round(prod_reg[0])));
            m_new_pos_y  <= sat_word(ACC_W'(ipos_reg[1]) + ACC_W'(dt_round(prod_reg[1])));
            m_new_vel_x  <= nvel_reg[0];
            m_new_vel_y  <= nvel_reg[1];
            m_overflowed <= cmd.ovf;
            m_final_res  <= cmd.final_item;
        end
    end

    assign m_valid        = mval_reg;
    assign stat.s_zero    = (s_reg == '0);
    assign stat.root_last = (cnt_reg == ITER_W'(ROOT_W - 1));
    assign stat.div_last  = (cnt_reg == ITER_W'(QUO_W - 1));
    assign stat.out_fire  = mval_reg & m_ready;
endmodule
`default_nettype wire

// ===== design/nbody_gravity_step_unit.sv =====
// nbody_gravity_step_unit: top level, softened 2D direct-sum gravity step.
// Depends on nbgs_pkg, nbgs_ctrl, nbgs_dpath (which uses nbgs_ram).
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | s_valid / s_ready  | s_pos_x/y, s_vel_x/y, s_mass, s_last
//   result   | m_valid / m_ready  | m_body_index, m_new_pos/vel_x/y, flags
//   config   | cfg_wr_en          | cfg_index, cfg_wr_data
//
// Loading accepts one item per cycle. After the last item, each ordered pair
// goes through a 33-step root, a 31-step divider and split multiplies, then
// every body is integrated and its result is offered in turn.
// Reset is synchronous and active low; the stores need no clearing pass.
// A stalled result holds the sequencer; no input is taken until the set drains.
`default_nettype none
module nbody_gravity_step_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [nbgs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nbgs_pkg::WORD_W-1:0]       cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [nbgs_pkg::WORD_W-1:0] s_pos_x,
    input  wire logic signed [nbgs_pkg::WORD_W-1:0] s_pos_y,
    input  wire logic signed [nbgs_pkg::WORD_W-1:0] s_vel_x,
    input  wire logic signed [nbgs_pkg::WORD_W-1:0] s_vel_y,
    input  wire logic [nbgs_pkg::MASS_W-1:0]       s_mass,
    input  wire logic                              s_last,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [nbgs_pkg::IDX_W-1:0]             m_body_index,
    output logic signed [nbgs_pkg::WORD_W-1:0]     m_new_pos_x,
    output logic signed [nbgs_pkg::WORD_W-1:0]     m_new_pos_y,
    output logic signed [nbgs_pkg::WORD_W-1:0]     m_new_vel_x,
    output logic signed [nbgs_pkg::WORD_W-1:0]     m_new_vel_y,
    output logic                                   m_overflowed,
    output logic                                   m_final_res
);
    import nbgs_pkg::*;

    cmd_t    cmd;
    status_t stat;

    // Sequencer
    nbgs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_last(s_last), .s_ready(s_ready),
        .stat(stat), .cmd(cmd)
    );

    // Stores and arithmetic
    nbgs_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_vel_x(s_vel_x), .s_vel_y(s_vel_y),
        .s_mass(s_mass),
        .m_valid(m_valid), .m_ready(m_ready), .m_body_index(m_body_index),
        .m_new_pos_x(m_new_pos_x), .m_new_pos_y(m_new_pos_y),
        .m_new_vel_x(m_new_vel_x), .m_new_vel_y(m_new_vel_y),
        .m_overflowed(m_overflowed), .m_final_res(m_final_res)
    );

`ifndef NO_ASSERTIONS
    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    // the last item closes the load window
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("load still open after last item");

    // taking the final result reopens loading
    a_final_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_final_res) |=> (s_ready && !m_valid))
        else $error("load not reopened after final result");
`endif
endmodule
`default_nettype wire

// ===== dv/tb_nbody_gravity_step_unit.sv =====
// tb_nbody_gravity_step_unit: self-checking testbench for the 2D gravity step unit.
// Depends on nbgs_pkg and nbody_gravity_step_unit; it predicts every updated body
// with its own fixed-point model and compares results in order.
`default_nettype none
module tb_nbody_gravity_step_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import nbgs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_SAT = 32'h7fffffff;

    typedef struct {
        logic signed [WORD_W-1:0] pos_x, pos_y, vel_x, vel_y;
        logic [MASS_W-1:0]        mass;
        logic                     last;
    } body_t;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [WORD_W-1:0] pos_x, pos_y, vel_x, vel_y;
        logic                     ovf, fin;
    } update_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [WORD_W-1:0] s_pos_x = '0, s_pos_y = '0, s_vel_x = '0, s_vel_y = '0;
    logic [MASS_W-1:0] s_mass = '0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [IDX_W-1:0] m_body_index;
    logic signed [WORD_W-1:0] m_new_pos_x, m_new_pos_y, m_new_vel_x, m_new_vel_y;
    logic m_overflowed, m_final_res;

    nbody_gravity_step_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_vel_x(s_vel_x), .s_vel_y(s_vel_y),
        .s_mass(s_mass), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_body_index(m_body_index),
        .m_new_pos_x(m_new_pos_x), .m_new_pos_y(m_new_pos_y),
        .m_new_vel_x(m_new_vel_x), .m_new_vel_y(m_new_vel_y),
        .m_overflowed(m_overflowed), .m_final_res(m_final_res)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor state: register copies and the set being loaded
    logic [WORD_W-1:0] k_grav = GRAV_RST;
    logic [WORD_W-1:0] k_dt   = DT_RST;
    logic [WORD_W-1:0] k_soft = SOFT_RST;
    longint set_pos[MAX_BODIES][2];
    longint set_vel[MAX_BODIES][2];
    logic [MASS_W-1:0] set_mass[MAX_BODIES];
    int set_count = 0;
    bit set_dropped = 0;

    body_t   pending_bodies[$];
    update_t expected_updates[$];
    int err_cnt = 0;
    int item_total = 0;

    function automatic longint sat_w(longint x);
        if (x > longint'(MAX_SAT)) return longint'(MAX_SAT);
        if (x < -longint'(MAX_SAT) - 1) return -longint'(MAX_SAT) - 1;
        return x;
    endfunction

    // (x * dt + 2^31) >> 32, floor
    function automatic longint times_dt(longint x);
        longint p;
        p = x * longint'(k_dt) + 64'sh80000000;
        return p >>> 32;
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] x);
        logic [127:0] r, c;
        r = '0;
        for (int b = 42; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    // One axis of one pair: K*m*|d|*2^F / den, saturated, signed like d
    function automatic longint pull_term(logic [127:0] km, longint d, logic [127:0] den);
        logic [127:0] ad, q;
        longint mag;
        ad = (d < 0) ? 128'(-d) : 128'(d);
        if (ad == 0) return 0;
        q = ((km * ad) << FRAC_BITS) / den;
        mag = (q > 128'(MAX_SAT)) ? longint'(MAX_SAT) : longint'(q[31:0]);
        return (d > 0) ? mag : -mag;
    endfunction

    // Run one gravity step over the loaded set and queue the updated bodies
    task automatic run_step();
        longint acc[MAX_BODIES][2];
        longint dx, dy, ax, ay, v, p;
        logic [127:0] ux, uy, s, root, den, km;
        update_t u;
        for (int i = 0; i < set_count; i++) begin
            ax = 0;
            ay = 0;
            for (int j = 0; j < set_count; j++) begin
                if (j == i) continue;
                dx = set_pos[j][0] - set_pos[i][0];
                dy = set_pos[j][1] - set_pos[i][1];
                ux = (dx < 0) ? 128'(-dx) : 128'(dx);
                uy = (dy < 0) ? 128'(-dy) : 128'(dy);
                s = ((ux * ux) >> FRAC_BITS) + ((uy * uy) >> FRAC_BITS) + 128'(k_soft);
                if (s == 0) continue;   // coincident and unsoftened: no pull
                root = isqrt(s << FRAC_BITS);
                den = s * root;
                km = 128'(k_grav) * 128'((set_mass[j] == 0) ? 16'd1 : set_mass[j]);
                ax += pull_term(km, dx, den);
                ay += pull_term(km, dy, den);
            end
            acc[i][0] = sat_w(ax);
            acc[i][1] = sat_w(ay);
        end
        // semi-implicit Euler: velocity first, then position
        for (int k = 0; k < set_count; k++) begin
            for (int a = 0; a < 2; a++) begin
                v = sat_w(set_vel[k][a] + times_dt(acc[k][a]));
                p = sat_w(set_pos[k][a] + times_dt(v));
                set_vel[k][a] = v;
                set_pos[k][a] = p;
            end
            u.idx = k[IDX_W-1:0];
            u.pos_x = set_pos[k][0][31:0];
            u.pos_y = set_pos[k][1][31:0];
            u.vel_x = set_vel[k][0][31:0];
            u.vel_y = set_vel[k][1][31:0];
            u.ovf = set_dropped;
            u.fin = (k + 1 == set_count);
            expected_updates.push_back(u);
        end
        set_count = 0;
        set_dropped = 0;
    endtask

    task automatic load_body(body_t b);
        if (set_count < MAX_BODIES) begin
            set_pos[set_count][0] = longint'(b.pos_x);
            set_pos[set_count][1] = longint'(b.pos_y);
            set_vel[set_count][0] = longint'(b.vel_x);
            set_vel[set_count][1] = longint'(b.vel_y);
            set_mass[set_count] = b.mass;
            set_count++;
        end else begin
            set_dropped = 1;
        end
        if (b.last) run_step();
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // Monitor: predict on accepted inputs, check accepted results
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            load_body('{s_pos_x, s_pos_y, s_vel_x, s_vel_y, s_mass, s_last});
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_updates.size() == 0) begin
                report("unexpected result, body_index", m_body_index, 0);
            end else begin
                update_t e;
                e = expected_updates.pop_front();
                if (m_body_index !== e.idx) report("body_index", m_body_index, e.idx);
                if (m_new_pos_x !== e.pos_x) report("new_pos_x", m_new_pos_x, e.pos_x);
                if (m_new_pos_y !== e.pos_y) report("new_pos_y", m_new_pos_y, e.pos_y);
                if (m_new_vel_x !== e.vel_x) report("new_vel_x", m_new_vel_x, e.vel_x);
                if (m_new_vel_y !== e.vel_y) report("new_vel_y", m_new_vel_y, e.vel_y);
                if (m_overflowed !== e.ovf) report("overflowed", m_overflowed, e.ovf);
                if (m_final_res !== e.fin) report("final_res", m_final_res, e.fin);
            end
        end
    end

    // Driver: bursts of items separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    body_t next_body;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (burst_left > 0 && pending_bodies.size() > 0) begin
                next_body = pending_bodies.pop_front();
                s_valid <= 1'b1;
                s_pos_x <= next_body.pos_x;
                s_pos_y <= next_body.pos_y;
                s_vel_x <= next_body.vel_x;
                s_vel_y <= next_body.vel_y;
                s_mass <= next_body.mass;
                s_last <= next_body.last;
                burst_left <= burst_left - 1;
            end else begin
                s_valid <= 1'b0;
                if (burst_left == 0) begin
                    if (gap_left > 0) begin
                        gap_left <= gap_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: stall pattern, plus one long hold once results appear
    bit long_hold_armed = 0;
    bit long_hold_done = 0;
    int hold_cnt = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    always @(posedge aclk) begin
        if (long_hold_armed && !long_hold_done && (m_valid || hold_cnt > 0)) begin
            m_ready <= 1'b0;
            if (hold_cnt == 400) long_hold_done <= 1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(5, 60);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic add_body(int px, int py, int vx, int vy, int m, bit last);
        pending_bodies.push_back('{px, py, vx, vy, m[15:0], last});
        item_total++;
    endtask

    function automatic int rand_coord(bit near);
        if (near) return int'($urandom_range(0, 2097152)) - 1048576;
        return int'($urandom);
    endfunction

    task automatic add_rand_set(int n);
        bit near;
        int m;
        for (int i = 0; i < n; i++) begin
            near = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 5))
                0: m = 0;
                1: m = 65535;
                default: m = $urandom_range(0, 65535);
            endcase
            add_body(rand_coord(near), rand_coord(near), rand_coord(near),
                     rand_coord(near), m, i == n - 1);
        end
    endtask

    // Wait until every item is taken and every result checked
    task automatic wait_drained();
        while (pending_bodies.size() != 0 || s_valid || expected_updates.size() != 0)
            @(negedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_GRAV: k_grav = val;
            REG_DT:   k_dt = val;
            REG_SOFT: k_soft = val;
            default: ;
        endcase
    endtask

    // Stimulus sequence
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: single body, coincident zero-mass pair, extremes, small set
        add_body(12345, -6789, 65536, -65536, 7, 1);
        add_body(65536, 65536, 0, 0, 0, 0);
        add_body(65536, 65536, 0, 0, 0, 1);
        add_body(MAX_SAT, -MAX_SAT - 1, MAX_SAT, -MAX_SAT - 1, 65535, 0);
        add_body(-MAX_SAT - 1, MAX_SAT, -MAX_SAT - 1, MAX_SAT, 65535, 1);
        add_body(0, 0, 0, 0, 1000, 0);
        add_body(65536, 0, 0, 0, 1000, 0);
        add_body(0, 65536, 0, 0, 1000, 1);
        wait_drained();

        // strongest settings, no softening
        write_reg(REG_GRAV, 32'hffffffff);
        write_reg(REG_DT, 32'hffffffff);
        write_reg(REG_SOFT, 32'h0);
        write_reg(REG_UNUSED, 32'h12345678);
        add_body(-300000, 400000, 5, -5, 65535, 0);
        add_body(-300000, 400000, -5, 5, 0, 1);
        add_body(MAX_SAT, MAX_SAT, MAX_SAT, MAX_SAT, 65535, 0);
        add_body(-MAX_SAT - 1, -MAX_SAT - 1, -MAX_SAT - 1, -MAX_SAT - 1, 65535, 1);
        add_rand_set(4);
        wait_drained();

        // weakest settings, maximal softening
        write_reg(REG_GRAV, 32'h0);
        write_reg(REG_DT, 32'h0);
        write_reg(REG_SOFT, 32'hffffffff);
        add_rand_set(3);
        add_rand_set(5);
        wait_drained();

        // random settings, one overfull set ending on a dropped last item
        write_reg(REG_GRAV, $urandom);
        write_reg(REG_DT, $urandom);
        write_reg(REG_SOFT, $urandom);
        add_rand_set(MAX_BODIES + 2);
        wait_drained();

        // defaults again, with a long result hold early in the random sets
        write_reg(REG_GRAV, GRAV_RST);
        write_reg(REG_DT, DT_RST);
        write_reg(REG_SOFT, SOFT_RST);
        long_hold_armed = 1;
        while (item_total < 300) add_rand_set($urandom_range(1, 7));
        wait_drained();

        // random settings for the remainder
        write_reg(REG_GRAV, $urandom);
        write_reg(REG_DT, $urandom_range(0, 2000000));
        write_reg(REG_SOFT, $urandom_range(0, 3) == 0 ? 0 : $urandom);
        while (item_total < 470) add_rand_set($urandom_range(1, 7));
        wait_drained();

        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
